// ----- design/ncd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types and constants of the nonuniform central difference block.
// ----------------------------------------------------------------------------
package ncd_pkg;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] position;
    logic               last_sample;
  } ncd_in_t;

  typedef struct packed {
    logic [31:0]        out_time;
    logic signed [31:0] out_position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic               bad_interval;
    logic               end_of_run;
  } ncd_out_t;

  localparam int unsigned NumW = 96;
  localparam int unsigned DenW = 33;
  localparam int unsigned CntW = 7;
  localparam logic [19:0] Usec = 20'd1000000;
  localparam logic [20:0] AccScale = 21'd2000000;
  localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48Min = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEL, ST_VP, ST_VA, ST_ACC_Q, ST_ACC_R, ST_FINISH, ST_EMIT
  } ncd_state_e;

  typedef enum logic [2:0] {
    DV_VEL, DV_VP, DV_VA, DV_ACC_Q, DV_ACC_R
  } ncd_div_e;

  typedef struct packed {
    logic     load_in;
    logic     start_div;
    ncd_div_e div_sel;
    logic     finish;
    logic [1:0] emit_sel;
    logic     shift_win;
  } ncd_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic bad;
  } ncd_sts_t;

endpackage

// ----- design/ncd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_datapath
// Sample window, shared restoring signed divider and result formation.
// ----------------------------------------------------------------------------
module ncd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ncd_pkg::ncd_in_t  in_i,
  input  ncd_pkg::ncd_cmd_t cmd_i,
  output ncd_pkg::ncd_sts_t sts_o,
  output ncd_pkg::ncd_out_t word_o
);
  import ncd_pkg::*;

  logic [31:0] t0_q, t1_q, t2_q;
  logic [31:0] p0_q, p1_q, p2_q;
  logic        last_q;
  logic signed [47:0] vel_q, acc_q;
  logic signed [63:0] vp_q, va_q;
  logic signed [63:0] q_q;
  logic signed [40:0] r_q;
  logic        bad_q;

  logic [NumW-1:0] rem_q, quo_q;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;

  logic [32:0] dtp, dta, dts;
  logic signed [32:0] x0, x1, x2;
  logic signed [NumW-1:0] num_s;
  logic [DenW-1:0] den_s;
  logic signed [64:0] diff;
  logic [NumW-1:0] num_abs;
  logic [NumW:0]   trial;
  logic signed [NumW-1:0] quo_s;
  logic signed [63:0] qlim;
  logic signed [96:0] acc_full;
  logic signed [NumW-1:0] usec_w, accs_w;
  logic            bad_s;

  assign dtp  = {1'b0, t1_q - t0_q};
  assign dta  = {1'b0, t2_q - t1_q};
  assign dts  = dtp + dta;
  assign x0   = 33'(signed'(p0_q));
  assign x1   = 33'(signed'(p1_q));
  assign x2   = 33'(signed'(p2_q));
  assign diff = 65'(va_q) - 65'(vp_q);
  assign qlim = 64'sd70368745;
  assign usec_w = $signed(NumW'(Usec));
  assign accs_w = $signed(NumW'(AccScale));
  assign bad_s  = !(in_i.sample_time > t1_q && t1_q > t0_q);

  always_comb begin
    num_s = '0;
    den_s = dts;
    case (cmd_i.div_sel)
      DV_VEL:   begin num_s = NumW'(x2 - x0) * usec_w; den_s = dts; end
      DV_VP:    begin num_s = NumW'(x1 - x0) * usec_w; den_s = dtp; end
      DV_VA:    begin num_s = NumW'(x2 - x1) * usec_w; den_s = dta; end
      DV_ACC_Q: begin num_s = NumW'(diff); den_s = dts; end
      DV_ACC_R: begin num_s = NumW'(r_q) * accs_w; den_s = dts; end
      default:  begin num_s = '0; den_s = dts; end
    endcase
  end

  assign num_abs = num_s[NumW-1] ? NumW'(-num_s) : num_s;
  assign trial   = {rem_q, quo_q[NumW-1]} - {{(NumW-DenW+1){1'b0}}, den_q};
  assign quo_s   = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start_div) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      rem_q <= '0;
      quo_q <= num_abs;
      den_q <= den_s;
      neg_q <= num_s[NumW-1];
    end else if (busy_q) begin
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    acc_full = 97'($signed(q_q[27:0])) * $signed({1'b0, AccScale}) + 97'(quo_s);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t2_q   <= in_i.sample_time;
      p2_q   <= in_i.position;
      last_q <= in_i.last_sample;
      bad_q  <= bad_s;
    end
    if (cmd_i.load_in && bad_s) begin
      vel_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.finish) begin
      case (cmd_i.div_sel)
        DV_VEL: begin
          if (quo_s > 96'(S48Max)) vel_q <= S48Max;
          else if (quo_s < 96'(S48Min)) vel_q <= S48Min;
          else vel_q <= quo_s[47:0];
        end
        DV_VP: vp_q <= quo_s[63:0];
        DV_VA: va_q <= quo_s[63:0];
        DV_ACC_Q: begin
          q_q <= quo_s[63:0];
          r_q <= neg_q ? -$signed(41'(rem_q)) : $signed(41'(rem_q));
        end
        DV_ACC_R: begin
          if (q_q > qlim) acc_q <= S48Max;
          else if (q_q < -qlim) acc_q <= S48Min;
          else if (acc_full > 97'(S48Max)) acc_q <= S48Max;
          else if (acc_full < 97'(S48Min)) acc_q <= S48Min;
          else acc_q <= acc_full[47:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.shift_win) begin
      t0_q <= t1_q;
      p0_q <= p1_q;
      if (cmd_i.load_in) begin
        t1_q <= in_i.sample_time;
        p1_q <= in_i.position;
      end else begin
        t1_q <= t2_q;
        p1_q <= p2_q;
      end
    end
  end

  assign sts_o.div_busy = busy_q;
  assign sts_o.bad      = bad_q;

  always_comb begin
    word_o = '0;
    word_o.velocity     = vel_q;
    word_o.acceleration = acc_q;
    word_o.bad_interval = bad_q;
    case (cmd_i.emit_sel)
      2'd0: begin word_o.out_time = t0_q; word_o.out_position = p0_q; end
      2'd1: begin word_o.out_time = t1_q; word_o.out_position = p1_q; end
      default: begin
        word_o.out_time = t2_q; word_o.out_position = p2_q;
        word_o.end_of_run = last_q;
      end
    endcase
  end

endmodule

// ----- design/ncd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_ctrl
// Sequencer: window fill, divide schedule and result emission.
// ----------------------------------------------------------------------------
module ncd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              zero_o,
  output logic              end_o,
  output ncd_pkg::ncd_cmd_t cmd_o,
  input  ncd_pkg::ncd_sts_t sts_i
);
  import ncd_pkg::*;

  ncd_state_e state_q, state_d;
  logic [1:0] fill_q, fill_d;
  logic [1:0] sel_q, sel_d;
  logic [1:0] stop_q, stop_d;
  logic       zero_q, zero_d;
  logic       started_q, started_d;
  logic       lastin_q;
  logic       acc_in;

  assign in_stall  = (state_q != ST_IDLE);
  assign out_valid = (state_q == ST_EMIT);
  assign acc_in    = in_valid && !in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; fill_q <= '0; sel_q <= '0; stop_q <= '0;
      zero_q <= 1'b0; started_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; sel_q <= sel_d; stop_q <= stop_d;
      zero_q <= zero_d; started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lastin_q <= 1'b0;
    else if (acc_in) lastin_q <= in_last_i;
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; sel_d = sel_q; stop_d = stop_q;
    zero_d = zero_q; started_d = 1'b0;
    cmd_o = '0;
    cmd_o.emit_sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          cmd_o.load_in = 1'b1;
          case (fill_q)
            2'd0: begin
              if (in_last_i) begin
                zero_d = 1'b1; sel_d = 2'd2; stop_d = 2'd2; state_d = ST_EMIT;
              end else begin
                cmd_o.shift_win = 1'b1; fill_d = 2'd1;
              end
            end
            2'd1: begin
              if (in_last_i) begin
                zero_d = 1'b1; sel_d = 2'd1; stop_d = 2'd2; state_d = ST_EMIT;
              end else begin
                cmd_o.shift_win = 1'b1; fill_d = 2'd2;
              end
            end
            default: begin
              zero_d = 1'b0; state_d = ST_VEL; started_d = 1'b1;
            end
          endcase
        end
      end
      ST_VEL, ST_VP, ST_VA, ST_ACC_Q, ST_ACC_R: begin
        case (state_q)
          ST_VEL:   cmd_o.div_sel = DV_VEL;
          ST_VP:    cmd_o.div_sel = DV_VP;
          ST_VA:    cmd_o.div_sel = DV_VA;
          ST_ACC_Q: cmd_o.div_sel = DV_ACC_Q;
          default:  cmd_o.div_sel = DV_ACC_R;
        endcase
        if (sts_i.bad) begin
          state_d = ST_FINISH;
        end else if (started_q) begin
          cmd_o.start_div = 1'b1;
        end else if (!sts_i.div_busy) begin
          cmd_o.finish = 1'b1;
          started_d = 1'b1;
          case (state_q)
            ST_VEL:   state_d = ST_VP;
            ST_VP:    state_d = ST_VA;
            ST_VA:    state_d = ST_ACC_Q;
            ST_ACC_Q: state_d = ST_ACC_R;
            default: begin
              state_d = ST_FINISH; started_d = 1'b0;
            end
          endcase
        end
      end
      ST_FINISH: begin
        sel_d = (fill_q == 2'd2) ? 2'd0 : 2'd1;
        stop_d = lastin_q ? 2'd2 : 2'd1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (sel_q == stop_q) begin
            state_d = ST_IDLE;
            if (stop_q == 2'd2) fill_d = 2'd0;
            else begin
              fill_d = 2'd3; cmd_o.shift_win = 1'b1;
            end
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign zero_o = zero_q;
  assign end_o  = (sel_q == 2'd2) && lastin_q;

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_emit_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !sts_i.div_busy) else $error("divider busy at emit");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> sel_q <= stop_q) else $error("emit index past end");
`endif

endmodule

// ----- design/nonuniform_central_difference.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonuniform_central_difference
// Three-point derivative estimator over timestamped position samples.
// ----------------------------------------------------------------------------
// Each sample that completes a three-sample window with rising timestamps runs
// five signed divides through one shared 96-bit restoring divider, one quotient
// bit a cycle; result words then leave one per cycle while out_stall is low.
// A window with a non-rising timestamp skips the divides, and samples that only
// fill the window are loaded without a divide. Input is stalled while work or
// emission of an item is in progress.
module nonuniform_central_difference (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  ncd_pkg::ncd_in_t  in_data_i,
  output logic              out_valid,
  input  logic              out_stall,
  output ncd_pkg::ncd_out_t out_data_o
);
  import ncd_pkg::*;

  ncd_cmd_t cmd;
  ncd_sts_t sts;
  ncd_out_t word;
  logic     zero, eor;

  ncd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_last_i(in_data_i.last_sample),
    .out_valid, .out_stall, .zero_o(zero), .end_o(eor), .cmd_o(cmd), .sts_i(sts)
  );

  ncd_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .word_o(word)
  );

  always_comb begin
    out_data_o = word;
    out_data_o.end_of_run = eor;
    if (zero) begin
      out_data_o.velocity     = '0;
      out_data_o.acceleration = '0;
      out_data_o.bad_interval = 1'b0;
    end
  end

endmodule
